[rtl/hfd_pkg.sv]
// Header frame deframer package: header codes, stage codes and the frame record.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package hfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 16;

    // header bytes, in order
    localparam logic [BYTE_W-1:0] HDR_B0 = 8'h48;
    localparam logic [BYTE_W-1:0] HDR_B1 = 8'h45;
    localparam logic [BYTE_W-1:0] HDR_B2 = 8'h4C;
    localparam logic [BYTE_W-1:0] HDR_B3 = 8'h4F;

    // header stage codes
    localparam int unsigned STAGE_W = 3;
    localparam logic [STAGE_W-1:0] STG_HUNT    = 3'd0;
    localparam logic [STAGE_W-1:0] STG_GOT_B0  = 3'd1;
    localparam logic [STAGE_W-1:0] STG_GOT_B1  = 3'd2;
    localparam logic [STAGE_W-1:0] STG_GOT_B2  = 3'd3;
    localparam logic [STAGE_W-1:0] STG_PAYLOAD = 3'd4;

    // payload bytes before the checksum
    localparam int unsigned IDX_W = 3;
    localparam logic [IDX_W-1:0] PAYLOAD_LEN = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] hour_field;
        logic [BYTE_W-1:0] minute_field;
        logic [BYTE_W-1:0] second_field;
        logic [BYTE_W-1:0] track_field;
        logic [BYTE_W-1:0] command_field;
        logic [DATA_W-1:0] data_word;
        logic              checksum_ok;
    } frame_t;

endpackage

`default_nettype wire

[rtl/hfd_byte_if.sv]
// Received-byte channel: valid/ready handshake with one byte of payload.
// Depends on hfd_pkg.
`default_nettype none

interface hfd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [hfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/hfd_frame_if.sv]
// Decoded frame channel: valid/ready handshake with the frame fields.
// Depends on hfd_pkg.
`default_nettype none

interface hfd_frame_if;
    logic                       valid;
    logic                       ready;
    logic [hfd_pkg::BYTE_W-1:0] hour_field;
    logic [hfd_pkg::BYTE_W-1:0] minute_field;
    logic [hfd_pkg::BYTE_W-1:0] second_field;
    logic [hfd_pkg::BYTE_W-1:0] track_field;
    logic [hfd_pkg::BYTE_W-1:0] command_field;
    logic [hfd_pkg::DATA_W-1:0] data_word;
    logic                       checksum_ok;

    modport source (output valid, output hour_field, output minute_field,
                    output second_field, output track_field, output command_field,
                    output data_word, output checksum_ok, input ready);
    modport sink   (input valid, input hour_field, input minute_field,
                    input second_field, input track_field, input command_field,
                    input data_word, input checksum_ok, output ready);
endinterface

`default_nettype wire

[rtl/hfd_core.sv]
// Deframer core: header hunt, payload capture, running sum and checksum check.
// Depends on hfd_pkg.
`default_nettype none

module hfd_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       byte_vld,
    input  wire logic [hfd_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                       out_space,
    output      logic                       take,
    output      logic                       frame_load,
    output      hfd_pkg::frame_t            frame
);
    import hfd_pkg::*;

    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  store_reg [PAYLOAD_LEN];
    logic               at_check;
    logic               capture;

    // checksum byte is the only one that needs room downstream
    assign at_check   = (stage_reg == STG_PAYLOAD) && (idx_reg == PAYLOAD_LEN);
    assign take       = byte_vld && (!at_check || out_space);
    assign frame_load = take && at_check;
    assign capture    = take && (stage_reg == STG_PAYLOAD) && !at_check;

    always_comb
    begin
        stage_next = stage_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        if (take)
        begin
            if (stage_reg != STG_PAYLOAD)
            begin
                case (byte_in)
                    HDR_B0:
                    begin
                        if (stage_reg == STG_HUNT) stage_next = STG_GOT_B0;
                    end
                    HDR_B1:
                    begin
                        if (stage_reg == STG_GOT_B0) stage_next = STG_GOT_B1;
                    end
                    HDR_B2:
                    begin
                        if (stage_reg == STG_GOT_B1) stage_next = STG_GOT_B2;
                    end
                    HDR_B3:
                    begin
                        if (stage_reg == STG_GOT_B2) stage_next = STG_PAYLOAD;
                    end
                    default:
                    begin
                        stage_next = STG_HUNT;
                    end
                endcase
            end
            else if (!at_check)
            begin
                idx_next = idx_reg + IDX_W'(1);
                sum_next = sum_reg + byte_in;
            end
            else
            begin
                stage_next = STG_HUNT;
                idx_next   = '0;
                sum_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STG_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            store_reg[idx_reg] <= byte_in;
        end
    end

    // sum of seven plus checksum wraps to zero when the frame is good
    always_comb
    begin
        frame.hour_field    = store_reg[0];
        frame.minute_field  = store_reg[1];
        frame.second_field  = store_reg[2];
        frame.track_field   = store_reg[3];
        frame.command_field = store_reg[4];
        frame.data_word     = {store_reg[6], store_reg[5]};
        frame.checksum_ok   = (BYTE_W'(sum_reg + byte_in) == '0);
    end

    a_frame_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        frame_load |=> (stage_reg == STG_HUNT) && (idx_reg == '0) && (sum_reg == '0))
        else $error("core did not restart hunt after checksum byte");

    a_idx_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (stage_reg == STG_PAYLOAD))
        else $error("payload index moved outside payload stage");

    a_hold_without_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(stage_reg) && $stable(idx_reg) && $stable(sum_reg))
        else $error("core state changed without a byte taken");

endmodule

`default_nettype wire

[rtl/hfd_out_stage.sv]
// Output register for decoded frames, holding a frame until the sink takes it.
// Depends on hfd_pkg.
`default_nettype none

module hfd_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire hfd_pkg::frame_t data_in,
    input  wire logic            sink_ready,
    output      logic            space,
    output      logic            vld,
    output      hfd_pkg::frame_t data_out
);
    import hfd_pkg::*;

    logic   vld_reg, vld_next;
    frame_t data_reg;

    assign space    = !vld_reg || sink_ready;
    assign vld_next = load || (vld_reg && !sink_ready);
    assign vld      = vld_reg;
    assign data_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_in;
        end
    end

endmodule

`default_nettype wire

[rtl/header_frame_deframer.sv]
// Top level of the header frame deframer: input register, core and output stage.
// Depends on hfd_pkg, hfd_byte_if, hfd_frame_if, hfd_core and hfd_out_stage.
`default_nettype none

// Channel  | Dir | Payload                                           | Transfer
// ---------+-----+---------------------------------------------------+-----------------
// rx       | in  | rx_byte[7:0]                                      | valid && ready
// frame    | out | hour, minute, second, track, command, data_word,  | valid && ready
//          |     | checksum_ok                                       |
//
// One byte per cycle unless a checksum byte is held: each transfer on rx is
// registered in the input register and decoded by the core from there. A frame
// is loaded into the output register when the core takes its checksum byte.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// core to hunting the first header byte.
// Only a checksum byte meeting a full output register that the sink does not
// drain holds the input register, and with it rx.ready.

module header_frame_deframer (
    input wire logic clk,
    input wire logic rst_n,
    hfd_byte_if.sink    rx,
    hfd_frame_if.source frame
);
    import hfd_pkg::*;

    // input register
    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;

    // core / output stage handshake
    logic   core_take;
    logic   frame_load;
    logic   out_space;
    logic   out_vld;
    frame_t core_frame;
    frame_t out_frame;

    // input register empties when the core takes its byte
    assign rx.ready    = !in_vld_reg || core_take;
    assign in_vld_next = (rx.valid && rx.ready) || (in_vld_reg && !core_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    hfd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_vld   (in_vld_reg),
        .byte_in    (in_byte_reg),
        .out_space  (out_space),
        .take       (core_take),
        .frame_load (frame_load),
        .frame      (core_frame)
    );

    hfd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (frame_load),
        .data_in    (core_frame),
        .sink_ready (frame.ready),
        .space      (out_space),
        .vld        (out_vld),
        .data_out   (out_frame)
    );

    assign frame.valid         = out_vld;
    assign frame.hour_field    = out_frame.hour_field;
    assign frame.minute_field  = out_frame.minute_field;
    assign frame.second_field  = out_frame.second_field;
    assign frame.track_field   = out_frame.track_field;
    assign frame.command_field = out_frame.command_field;
    assign frame.data_word     = out_frame.data_word;
    assign frame.checksum_ok   = out_frame.checksum_ok;

endmodule

`default_nettype wire
